// ===== rtl/core/pdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair digraph cipher package
// Item types, register indexes and small helpers for the 5x5 key square.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int SQUARE_SIDE  = 5;
  localparam int SQUARE_CELLS = SQUARE_SIDE * SQUARE_SIDE;
  localparam int CELL_W       = 5;
  localparam int SQUARE_W     = SQUARE_CELLS * CELL_W;
  localparam int LOW_W        = 50;
  localparam int MID_W        = 50;
  localparam int HIGH_W       = 25;
  localparam int CFG_DATA_W   = 50;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [2:0] SIDE_LAST = 3'd4;

  typedef logic [CELL_W-1:0]       letter_t;
  typedef logic [2:0]              coord_t;
  typedef logic [CELL_W-1:0]       cell_idx_t;
  typedef logic [SQUARE_CELLS-1:0] match_t;
  typedef logic [SQUARE_W-1:0]     square_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CELLS_LOW  = 2'd0,
    REG_CELLS_MID  = 2'd1,
    REG_CELLS_HIGH = 2'd2,
    REG_DIRECTION  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    letter_t letter_one;
    letter_t letter_two;
  } in_item_t;

  typedef struct packed {
    letter_t result_one;
    letter_t result_two;
    logic    letter_missing;
  } out_item_t;

  function automatic letter_t cell_at(input square_t square, input cell_idx_t idx);
    letter_t value;
    value = '0;
    for (int k = 0; k < SQUARE_CELLS; k++) begin
      if (idx == cell_idx_t'(k)) begin
        value = square[k*CELL_W +: CELL_W];
      end
    end
    return value;
  endfunction

  function automatic match_t match_cells(input square_t square, input letter_t letter);
    match_t hits;
    for (int k = 0; k < SQUARE_CELLS; k++) begin
      hits[k] = (square[k*CELL_W +: CELL_W] == letter);
    end
    return hits;
  endfunction

  function automatic coord_t step_fwd(input coord_t v);
    return (v < SIDE_LAST) ? coord_t'(v + 3'd1) : 3'd0;
  endfunction

  function automatic coord_t step_back(input coord_t v);
    return (v > 3'd0) ? coord_t'(v - 3'd1) : SIDE_LAST;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/playfair_digraph_cipher_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Playfair digraph cipher core
// Substitutes one letter pair per cycle against a 5x5 key square.
// ----------------------------------------------------------------------------
// Start passes the s1, s2, s3 and result valid registers to the strobe.
// Throughput is one item per cycle; busy is never raised.
// The stages are cell match, position encode, move rule and cell read.
// Synchronous reset clears the pipeline valid bits and the configuration
// registers to zero; the data path registers are not reset.
module playfair_digraph_cipher_core
  import pdc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire in_item_t               digraph,
  output logic                        result_valid,
  output out_item_t                   result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LOW_W-1:0]  cells_low;
  logic [MID_W-1:0]  cells_mid;
  logic [HIGH_W-1:0] cells_high;
  logic              direction;
  square_t           square;

  logic   s1_valid;
  match_t s1_hit_one;
  match_t s1_hit_two;

  logic   s2_valid;
  logic   s2_found_one;
  logic   s2_found_two;
  coord_t s2_row_one;
  coord_t s2_col_one;
  coord_t s2_row_two;
  coord_t s2_col_two;

  logic      s3_valid;
  logic      s3_missing;
  cell_idx_t s3_idx_one;
  cell_idx_t s3_idx_two;

  logic   found_one;
  logic   found_two;
  coord_t row_one;
  coord_t col_one;
  coord_t row_two;
  coord_t col_two;
  coord_t nrow_one;
  coord_t ncol_one;
  coord_t nrow_two;
  coord_t ncol_two;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign square    = {cells_high, cells_mid, cells_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_low  <= '0;
      cells_mid  <= '0;
      cells_high <= '0;
      direction  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CELLS_LOW:  cells_low  <= cfg_data[LOW_W-1:0];
        REG_CELLS_MID:  cells_mid  <= cfg_data[MID_W-1:0];
        REG_CELLS_HIGH: cells_high <= cfg_data[HIGH_W-1:0];
        REG_DIRECTION:  direction  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_one <= match_cells(square, digraph.letter_one);
    s1_hit_two <= match_cells(square, digraph.letter_two);
  end

  // The highest matching cell wins, so later cells override earlier ones.
  always_comb begin
    found_one = 1'b0;
    found_two = 1'b0;
    row_one   = '0;
    col_one   = '0;
    row_two   = '0;
    col_two   = '0;
    for (int k = 0; k < SQUARE_CELLS; k++) begin
      if (s1_hit_one[k]) begin
        found_one = 1'b1;
        row_one   = coord_t'(k / SQUARE_SIDE);
        col_one   = coord_t'(k % SQUARE_SIDE);
      end
      if (s1_hit_two[k]) begin
        found_two = 1'b1;
        row_two   = coord_t'(k / SQUARE_SIDE);
        col_two   = coord_t'(k % SQUARE_SIDE);
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_found_one <= found_one;
    s2_found_two <= found_two;
    s2_row_one   <= row_one;
    s2_col_one   <= col_one;
    s2_row_two   <= row_two;
    s2_col_two   <= col_two;
  end

  always_comb begin
    nrow_one = s2_row_one;
    ncol_one = s2_col_one;
    nrow_two = s2_row_two;
    ncol_two = s2_col_two;
    if (s2_row_one == s2_row_two) begin
      ncol_one = direction ? step_back(s2_col_one) : step_fwd(s2_col_one);
      ncol_two = direction ? step_back(s2_col_two) : step_fwd(s2_col_two);
    end else if (s2_col_one == s2_col_two) begin
      nrow_one = direction ? step_back(s2_row_one) : step_fwd(s2_row_one);
      nrow_two = direction ? step_back(s2_row_two) : step_fwd(s2_row_two);
    end else begin
      ncol_one = s2_col_two;
      ncol_two = s2_col_one;
    end
  end

  always_ff @(posedge clk) begin
    s3_missing <= !(s2_found_one && s2_found_two);
    s3_idx_one <= cell_idx_t'(nrow_one) * cell_idx_t'(SQUARE_SIDE) + cell_idx_t'(ncol_one);
    s3_idx_two <= cell_idx_t'(nrow_two) * cell_idx_t'(SQUARE_SIDE) + cell_idx_t'(ncol_two);
  end

  always_ff @(posedge clk) begin
    result.letter_missing <= s3_missing;
    result.result_one     <= s3_missing ? '0 : cell_at(square, s3_idx_one);
    result.result_two     <= s3_missing ? '0 : cell_at(square, s3_idx_two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= start;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

endmodule
`default_nettype wire
